### hdl/srdp_pkg.sv
// Package: types, constants and state codes of the sparse row displacement packer.
`default_nettype none
package srdp_pkg;
  localparam int TableDepth = 4096;
  localparam int MaxSymbols = 64;
  localparam int AddrW = $clog2(TableDepth);
  localparam int SizeW = AddrW + 1;
  localparam logic [SizeW-1:0] FloorGap = SizeW'(2000);
  localparam logic [SizeW-1:0] FloorBack = SizeW'(1000);

  localparam logic [1:0] TagEmpty = 2'd0;
  localparam logic [1:0] TagEmptyStart = 2'd1;
  localparam logic [1:0] TagOcc = 2'd2;
  localparam logic [1:0] TagOccStart = 2'd3;

  localparam logic [1:0] StPlaced = 2'd0;
  localparam logic [1:0] StNoFit = 2'd1;
  localparam logic [1:0] StFull = 2'd2;

  typedef struct packed {
    logic [63:0] symbol_mask;
    logic        row_final;
  } in_item_t;

  typedef struct packed {
    logic [11:0] base_slot;
    logic [1:0]  status;
    logic [12:0] used_size;
  } out_item_t;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_BASE, S_CHECK, S_MARK, S_OUT
  } state_t;
endpackage
`default_nettype wire

### hdl/sparse_row_displacement_packer_core.sv
// Top level: first-fit row packer over a slot tag memory.
//
// Usage: a request (symbol_mask, row_final) enters on in_valid/in_stall; one
// result (base_slot, status, used_size) leaves on out_valid/out_stall.
// The user must write the symbol count through cfg_we/cfg_data only while
// idle; the block itself does not enforce this. One request at a time. The
// tag memory has one read/write port with a registered read; each candidate
// base costs one read of its own slot plus one read per set mask bit (a read
// of a hit ends the candidate). Placement writes the base slot, then reads
// and rewrites each symbol slot of a set bit. out_valid rises in the cycle
// after the search or placement ends.
// After reset a clearing pass writes all 4096 tags empty with in_stall high.
// The result sits in an output register until out_stall is low; a new
// request is taken in the cycle after that result is taken.
`default_nettype none
module sparse_row_displacement_packer_core (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    cfg_we,
  input  wire [6:0]              cfg_data,
  input  wire                    in_valid,
  output logic                   in_stall,
  input  srdp_pkg::in_item_t     in_data,
  output logic                   out_valid,
  input  wire                    out_stall,
  output srdp_pkg::out_item_t    out_data
);
  import srdp_pkg::*;

  logic [1:0] tags [TableDepth];
  logic [1:0] rd;
  logic       we;
  logic [AddrW-1:0] addr;
  logic [1:0] wd;

  state_t state;
  logic [6:0] sym_reg;
  logic [SizeW-1:0] alloc;
  logic [AddrW-1:0] floor_q;
  logic armed;
  logic [63:0] mask;
  logic [63:0] work;
  logic fin;
  logic [SizeW-1:0] idx;
  logic [5:0] bitpos;
  logic [AddrW-1:0] clr;
  logic [1:0] base_tag;
  logic [1:0] st;
  logic [AddrW-1:0] base_q;
  logic pend;

  logic [6:0] n;
  assign n = (sym_reg == 7'd0) ? 7'd1 : (sym_reg > 7'(MaxSymbols)) ? 7'(MaxSymbols) : sym_reg;

  logic [5:0] lowbit;
  always_comb begin
    lowbit = 6'd0;
    for (int i = 63; i >= 0; i--) if (work[i]) lowbit = 6'(i);
  end

  // slot address of symbol bit (may exceed the table)
  logic [SizeW:0] saddr;
  assign saddr = {1'b0, idx} + (SizeW+1)'(lowbit) + (SizeW+1)'(1);
  logic s_in;
  assign s_in = saddr < (SizeW+1)'(TableDepth);

  always_ff @(posedge clk) begin
    if (we) tags[addr] <= wd;
    rd <= tags[addr];
  end

  logic [SizeW:0] grow;
  assign grow = {1'b0, alloc} + (SizeW+1)'(n) + (SizeW+1)'(1);
  logic [SizeW:0] win;
  assign win = {1'b0, idx} + (SizeW+1)'(n) + (SizeW+1)'(1);

  always_comb begin
    we = 1'b0;
    addr = idx[AddrW-1:0];
    wd = TagEmpty;
    unique case (state)
      S_CLEAR: begin we = 1'b1; addr = clr; end
      S_CHECK: addr = saddr[AddrW-1:0];
      S_MARK: begin
        if (pend) begin
          we = 1'b1; addr = base_q;
          wd = (fin || base_tag == TagOcc) ? TagOccStart : TagEmptyStart;
        end else begin
          we = s_in && mark_rd; addr = saddr[AddrW-1:0];
          wd = (rd == TagEmpty) ? TagOcc : TagOccStart;
        end
      end
      default: ;
    endcase
  end

  assign in_stall = (state != S_IDLE);
  assign out_valid = (state == S_OUT);

  // S_BASE: issue read of base slot. S_CHECK: rd holds previous read.
  logic chk_first;
  logic mark_rd;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr <= '0;
      sym_reg <= 7'd64;
      alloc <= SizeW'(65);
      floor_q <= '0;
      armed <= 1'b0;
    end else begin
      if (cfg_we) sym_reg <= cfg_data;
      unique case (state)
        S_CLEAR: begin
          clr <= clr + AddrW'(1);
          if (&clr) state <= S_IDLE;
        end
        S_IDLE: if (in_valid) begin
          logic [AddrW-1:0] f;
          f = floor_q;
          if (armed) begin
            if (alloc > FloorGap && {1'b0, f} < alloc - FloorGap)
              f = AddrW'(alloc - FloorBack);
            if (f < AddrW'(TableDepth - 1)) f = f + AddrW'(1);
          end
          floor_q <= f;
          armed <= 1'b1;
          mask <= (n < 7'd64) ? (in_data.symbol_mask & ((64'd1 << n) - 64'd1))
                              : in_data.symbol_mask;
          fin <= in_data.row_final;
          idx <= {1'b0, f};
          st <= StNoFit;
          base_q <= '0;
          state <= S_BASE;
        end
        S_BASE: begin
          if (idx >= alloc) state <= S_OUT;
          else if (win >= {1'b0, alloc} && grow > (SizeW+1)'(TableDepth)) begin
            st <= StFull; state <= S_OUT;
          end else begin
            if (win >= {1'b0, alloc}) alloc <= grow[SizeW-1:0];
            work <= mask;
            chk_first <= 1'b1;
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          logic fail;
          fail = 1'b0;
          if (chk_first) begin
            base_tag <= rd;
            if (rd == TagEmptyStart || rd == TagOccStart || (fin && rd == TagOcc)) fail = 1'b1;
          end else if (rd[1] && mark_rd) fail = 1'b1;
          chk_first <= 1'b0;
          mark_rd <= s_in;
          if (fail) begin
            idx <= idx + SizeW'(1); state <= S_BASE;
          end else if (work == 64'd0) begin
            st <= StPlaced; base_q <= idx[AddrW-1:0];
            work <= mask; pend <= 1'b1; state <= S_MARK;
          end else begin
            work <= work & (work - 64'd1);
          end
        end
        S_MARK: begin
          // base write first, then read-modify-write per bit (read lands next cycle)
          if (pend) begin
            pend <= 1'b0;
            mark_rd <= 1'b0;
            if (mask == 64'd0) state <= S_OUT;
          end else if (!mark_rd) begin
            mark_rd <= 1'b1;
          end else begin
            mark_rd <= 1'b0;
            work <= work & (work - 64'd1);
            if ((work & (work - 64'd1)) == 64'd0) state <= S_OUT;
          end
        end
        S_OUT: if (!out_stall) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  assign out_data.base_slot = (st == StPlaced) ? 12'(base_q) : 12'd0;
  assign out_data.status = st;
  assign out_data.used_size = 13'(alloc);

  a_stall_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("accepted while result pending");
  a_alloc_cap: assert property (@(posedge clk) disable iff (rst)
    alloc <= SizeW'(TableDepth)) else $error("allocation beyond table");
  a_floor_alloc: assert property (@(posedge clk) disable iff (rst)
    (state == S_CHECK) |-> (idx < alloc)) else $error("checking past used size");
endmodule
`default_nettype wire
